### rtl/ata_tf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_pkg
// Shared types and constants for the ATA task-file command setup block.
// ----------------------------------------------------------------------------
package ata_tf_pkg;

    // Task-file register offsets from the channel I/O base
    localparam logic [2:0] OFF_SECCOUNT = 3'd2;
    localparam logic [2:0] OFF_LBA0     = 3'd3;
    localparam logic [2:0] OFF_LBA1     = 3'd4;
    localparam logic [2:0] OFF_LBA2     = 3'd5;
    localparam logic [2:0] OFF_DEVSEL   = 3'd6;
    localparam logic [2:0] OFF_COMMAND  = 3'd7;

    // PIO commands
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // Device select base values
    localparam logic [7:0] SEL_LBA = 8'he0;
    localparam logic [7:0] SEL_CHS = 8'ha0;

    // First address that needs 48-bit addressing
    localparam logic [31:0] LBA28_LIMIT = 32'h1000_0000;

    // Reciprocals of 63: Q30 for a 24-bit dividend, Q16 for a 10-bit one
    localparam logic [24:0] RECIP63_Q30 = 25'd17043522;
    localparam logic [10:0] RECIP63_Q16 = 11'd1041;

    // Configuration register indexes
    localparam logic [1:0] CFG_LBA_CAPABLE = 2'd0;
    localparam logic [1:0] CFG_SLAVE       = 2'd1;
    localparam logic [1:0] CFG_CHANNEL     = 2'd2;

    typedef struct packed {
        logic [1:0]  device;
        logic        is_write;
        logic [31:0] lba;
        logic [7:0]  count;
    } t_req;

    // Everything the sequencer needs to emit one run of writes
    typedef struct packed {
        logic       chan;
        logic       ext;      // LBA48 run
        logic       chs;      // CHS geometry
        logic       is_write;
        logic [7:0] sel;      // device select byte
        logic [7:0] count;
        logic [7:0] hi;       // LBA bits 31..24
        logic [7:0] lo;       // LBA bits 7..0
        logic [7:0] b1;
        logic [7:0] b2;
        logic [9:0] v;        // lba mod 1008
        logic [3:0] head;
    } t_plan;

endpackage

### rtl/ata_tf_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_plan
// Two-stage address planner: picks the addressing mode and works out CHS.
// ----------------------------------------------------------------------------
module ata_tf_plan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_vld,
    input  ata_tf_pkg::t_req   i_req,
    output logic               o_req_rdy,
    input  logic [3:0]         i_lba_capable_mask,
    input  logic [3:0]         i_slave_mask,
    input  logic [3:0]         i_channel_mask,
    output logic               o_plan_vld,
    output ata_tf_pkg::t_plan  o_plan,
    input  logic               i_plan_rdy
);

    logic              r_s1_vld;
    ata_tf_pkg::t_req  r_s1_req;
    logic              r_s1_ext;
    logic              r_s1_lba_ok;
    logic              r_s1_chan;
    logic              r_s1_slave;
    logic [18:0]       r_s1_q;

    logic              r_s2_vld;
    ata_tf_pkg::t_plan r_s2_plan;

    logic              w_s1_en;
    logic              w_s2_en;
    logic [48:0]       w_qprod;
    logic [24:0]       w_q63;
    logic [24:0]       w_rem;
    logic [9:0]        w_v;
    logic [20:0]       w_hprod;
    logic [3:0]        w_head;
    logic              w_chs;
    ata_tf_pkg::t_plan n_s2_plan;

    assign w_s2_en   = !r_s2_vld || i_plan_rdy;
    assign w_s1_en   = !r_s1_vld || w_s2_en;
    assign o_req_rdy = w_s1_en;

    // stage 1: (lba / 16) / 63 by reciprocal
    assign w_qprod = 49'(i_req.lba[27:4]) * 49'(ata_tf_pkg::RECIP63_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_vld <= i_req_vld;
        end
        if (w_s1_en && i_req_vld) begin
            r_s1_req    <= i_req;
            r_s1_ext    <= (i_req.lba >= ata_tf_pkg::LBA28_LIMIT);
            r_s1_lba_ok <= i_lba_capable_mask[i_req.device];
            r_s1_chan   <= i_channel_mask[i_req.device];
            r_s1_slave  <= i_slave_mask[i_req.device];
            r_s1_q      <= w_qprod[48:30];
        end
    end

    // stage 2: remainder, lba mod 1008, head
    assign w_q63   = {r_s1_q, 6'b0} - 25'(r_s1_q);
    assign w_rem   = 25'(r_s1_req.lba[27:4]) - w_q63;
    assign w_v     = {w_rem[5:0], r_s1_req.lba[3:0]};
    assign w_hprod = 21'(w_v) * 21'(ata_tf_pkg::RECIP63_Q16);
    assign w_head  = w_hprod[19:16];
    assign w_chs   = !r_s1_ext && !r_s1_lba_ok;

    always_comb begin
        n_s2_plan          = '0;
        n_s2_plan.chan     = r_s1_chan;
        n_s2_plan.ext      = r_s1_ext;
        n_s2_plan.chs      = w_chs;
        n_s2_plan.is_write = r_s1_req.is_write;
        n_s2_plan.count    = r_s1_req.count;
        n_s2_plan.hi       = r_s1_req.lba[31:24];
        n_s2_plan.lo       = r_s1_req.lba[7:0];
        n_s2_plan.v        = w_v;
        n_s2_plan.head     = w_head;
        priority if (r_s1_ext) begin
            n_s2_plan.sel = ata_tf_pkg::SEL_LBA | {3'b0, r_s1_slave, 4'b0};
        end else if (r_s1_lba_ok) begin
            n_s2_plan.sel = ata_tf_pkg::SEL_LBA | {3'b0, r_s1_slave, r_s1_req.lba[27:24]};
        end else begin
            n_s2_plan.sel = ata_tf_pkg::SEL_CHS | {3'b0, r_s1_slave, w_head};
        end
        if (w_chs) begin
            n_s2_plan.b1 = r_s1_q[7:0];
            n_s2_plan.b2 = r_s1_q[15:8];
        end else begin
            n_s2_plan.b1 = r_s1_req.lba[15:8];
            n_s2_plan.b2 = r_s1_req.lba[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_s2_en && r_s1_vld) begin
            r_s2_plan <= n_s2_plan;
        end
    end

    assign o_plan_vld = r_s2_vld;
    assign o_plan     = r_s2_plan;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (w_rem < 25'd63))
        else $error("CHS remainder out of range");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (10'(w_head) * 10'd63 <= w_v) && (w_v - 10'(w_head) * 10'd63 < 10'd63))
        else $error("CHS head quotient wrong");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !i_plan_rdy) |=> (r_s2_vld && $stable(r_s2_plan)))
        else $error("plan lost while stalled");

endmodule

### rtl/ata_tf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_seq
// Write sequencer: steps through one plan, one register write per cycle unless stalled.
// ----------------------------------------------------------------------------
module ata_tf_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_plan_vld,
    input  ata_tf_pkg::t_plan i_plan,
    output logic              o_plan_rdy,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,   // reg_offset[2:0], value[10:3], zero pad
    output logic              o_m_axis_tuser,   // channel
    output logic              o_m_axis_tlast
);

    localparam logic [3:0] STEP_DEVSEL = 4'd0;
    localparam logic [3:0] STEP_HI_CNT = 4'd1;
    localparam logic [3:0] STEP_HI_L0  = 4'd2;
    localparam logic [3:0] STEP_HI_L1  = 4'd3;
    localparam logic [3:0] STEP_HI_L2  = 4'd4;
    localparam logic [3:0] STEP_COUNT  = 4'd5;
    localparam logic [3:0] STEP_L0     = 4'd6;
    localparam logic [3:0] STEP_L1     = 4'd7;
    localparam logic [3:0] STEP_L2     = 4'd8;
    localparam logic [3:0] STEP_CMD    = 4'd9;

    logic              r_em_vld;
    ata_tf_pkg::t_plan r_plan;
    logic [3:0]        r_idx;
    logic [3:0]        n_idx;

    logic              r_out_vld;
    logic              r_out_chan;
    logic [2:0]        r_out_off;
    logic [7:0]        r_out_value;
    logic              r_out_last;

    logic              w_emit;
    logic              w_done;
    logic              w_load;
    logic [9:0]        w_sect;
    logic [2:0]        w_off;
    logic [7:0]        w_value;
    logic [7:0]        w_cmd;

    assign w_emit     = r_em_vld && (!r_out_vld || i_m_axis_tready);
    assign w_done     = w_emit && (r_idx == STEP_CMD);
    assign o_plan_rdy = !r_em_vld || w_done;
    assign w_load     = o_plan_rdy && i_plan_vld;

    // sector number = lba mod 63 + 1
    assign w_sect = r_plan.v - {r_plan.head, 6'b0} + 10'(r_plan.head) + 10'd1;

    always_comb begin
        priority if (r_plan.is_write) begin
            w_cmd = r_plan.ext ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_WRITE;
        end else begin
            w_cmd = r_plan.ext ? ata_tf_pkg::CMD_READ_EXT : ata_tf_pkg::CMD_READ;
        end
    end

    always_comb begin
        unique case (r_idx)
            STEP_DEVSEL: begin w_off = ata_tf_pkg::OFF_DEVSEL;   w_value = r_plan.sel;   end
            STEP_HI_CNT: begin w_off = ata_tf_pkg::OFF_SECCOUNT; w_value = 8'd0;         end
            STEP_HI_L0:  begin w_off = ata_tf_pkg::OFF_LBA0;     w_value = r_plan.hi;    end
            STEP_HI_L1:  begin w_off = ata_tf_pkg::OFF_LBA1;     w_value = 8'd0;         end
            STEP_HI_L2:  begin w_off = ata_tf_pkg::OFF_LBA2;     w_value = 8'd0;         end
            STEP_COUNT:  begin w_off = ata_tf_pkg::OFF_SECCOUNT; w_value = r_plan.count; end
            STEP_L0: begin
                w_off   = ata_tf_pkg::OFF_LBA0;
                w_value = r_plan.chs ? w_sect[7:0] : r_plan.lo;
            end
            STEP_L1:     begin w_off = ata_tf_pkg::OFF_LBA1;     w_value = r_plan.b1;    end
            STEP_L2:     begin w_off = ata_tf_pkg::OFF_LBA2;     w_value = r_plan.b2;    end
            STEP_CMD:    begin w_off = ata_tf_pkg::OFF_COMMAND;  w_value = w_cmd;        end
            default:     begin w_off = ata_tf_pkg::OFF_COMMAND;  w_value = 8'd0;         end
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (w_load) begin
            n_idx = STEP_DEVSEL;
        end else if (w_emit) begin
            unique case (r_idx)
                STEP_DEVSEL: n_idx = r_plan.ext ? STEP_HI_CNT : STEP_COUNT;
                STEP_CMD:    n_idx = STEP_CMD;
                default:     n_idx = r_idx + 4'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
            r_idx    <= STEP_DEVSEL;
        end else begin
            if (o_plan_rdy) begin
                r_em_vld <= i_plan_vld;
            end
            r_idx <= n_idx;
        end
        if (w_load) begin
            r_plan <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            r_out_vld <= w_emit;
        end
        if (w_emit) begin
            r_out_chan  <= r_plan.chan;
            r_out_off   <= w_off;
            r_out_value <= w_value;
            r_out_last  <= (r_idx == STEP_CMD);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out_value, r_out_off};
    assign o_m_axis_tuser  = r_out_chan;
    assign o_m_axis_tlast  = r_out_last;

    a_last_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last) |-> (r_out_off == ata_tf_pkg::OFF_COMMAND))
        else $error("last word is not the command write");

    a_no_hi_in_28: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_em_vld && !r_plan.ext) |-> !(r_idx == STEP_HI_CNT || r_idx == STEP_HI_L0 ||
                                        r_idx == STEP_HI_L1 || r_idx == STEP_HI_L2))
        else $error("high-order write in a 28-bit run");

    a_skip_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_idx == STEP_DEVSEL) |=> (r_idx == STEP_HI_CNT || r_idx == STEP_COUNT))
        else $error("bad step after device select");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= STEP_CMD)
        else $error("step index out of range");

endmodule

### rtl/ata_taskfile_command_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_taskfile_command_setup
// Turns one sector read/write request into its run of task-file writes.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tdata: device, block_address, sector_count
//                                   tuser: is_write
// m_axis    out  tvalid / tready    tdata: reg_offset, value; tuser: channel;
//                                   tlast: command write ends the run
// cfg       in   valid / ready      index (0 lba_capable, 1 slave, 2 channel), data
//
// Words: each request gives 6 words (LBA28/CHS) or 10 words (LBA48), one per
// cycle out of the sequencer unless m_axis stalls; runs follow each other
// with no gap. An accepted request passes the input register, the two planner
// stages, the sequencer plan load and the output register to its first word.
// Reset: synchronous, active low; clears valid flags and the three masks.
// Stalls: m_axis tready low holds the output word; the planner keeps taking
// requests until it and the input register fill, then s_axis tready drops.
// cfg is always ready; the user must write the masks only while the block is
// idle, as the block itself does not enforce it.
module ata_taskfile_command_setup (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // device[1:0], block_address[33:2],
                                          // sector_count[41:34], zero pad
    input  logic        i_s_axis_tuser,   // is_write

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // reg_offset[2:0], value[10:3], zero pad
    output logic        o_m_axis_tuser,   // channel
    output logic        o_m_axis_tlast,   // last

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    // configuration masks, bit d for device d
    logic [3:0]        r_lba_capable_mask;
    logic [3:0]        r_slave_mask;
    logic [3:0]        r_channel_mask;

    // input register
    logic              r_s0_vld;
    ata_tf_pkg::t_req  r_s0_req;
    ata_tf_pkg::t_req  w_in_req;
    logic              w_s0_rdy;

    logic              w_plan_vld;
    logic              w_plan_rdy;
    ata_tf_pkg::t_plan w_plan;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba_capable_mask <= 4'd0;
            r_slave_mask       <= 4'd0;
            r_channel_mask     <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ata_tf_pkg::CFG_LBA_CAPABLE: r_lba_capable_mask <= i_cfg_data;
                ata_tf_pkg::CFG_SLAVE:       r_slave_mask       <= i_cfg_data;
                ata_tf_pkg::CFG_CHANNEL:     r_channel_mask     <= i_cfg_data;
                default: ;   // unused index, ignored
            endcase
        end
    end

    // unpack the request word
    always_comb begin
        w_in_req.device   = i_s_axis_tdata[1:0];
        w_in_req.is_write = i_s_axis_tuser;
        w_in_req.lba      = i_s_axis_tdata[33:2];
        w_in_req.count    = i_s_axis_tdata[41:34];
    end

    // input stage drains whenever the planner takes it
    assign o_s_axis_tready = !r_s0_vld || w_s0_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s0_vld <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_s0_req <= w_in_req;
        end
    end

    ata_tf_plan u_plan (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_vld          (r_s0_vld),
        .i_req              (r_s0_req),
        .o_req_rdy          (w_s0_rdy),
        .i_lba_capable_mask (r_lba_capable_mask),
        .i_slave_mask       (r_slave_mask),
        .i_channel_mask     (r_channel_mask),
        .o_plan_vld         (w_plan_vld),
        .o_plan             (w_plan),
        .i_plan_rdy         (w_plan_rdy)
    );

    ata_tf_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_plan_vld      (w_plan_vld),
        .i_plan          (w_plan),
        .o_plan_rdy      (w_plan_rdy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_s0_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_vld && !w_s0_rdy) |=> (r_s0_vld && $stable(r_s0_req)))
        else $error("input register overwritten while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s0_vld |-> o_s_axis_tready)
        else $error("empty input stage not ready");

    a_cfg_applies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == ata_tf_pkg::CFG_SLAVE) |=> (r_slave_mask == $past(i_cfg_data)))
        else $error("slave mask write lost");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - ATA task-file command setup testbench
// Sends read/write requests over the input stream and checks every task-file
// register write that comes back against a local model of the addressing
// rules (LBA48 / LBA28 / CHS), the device masks and the command encoding.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 4000;  // cycles with no word moving anywhere
    localparam int HOLD_CYCLES   = 400;   // long output hold-off for the fill test
    localparam int TAIL_CYCLES   = 24;    // pipeline depth plus one full LBA48 run

    // One task-file register write as seen on the output stream
    typedef struct packed {
        logic       chan;
        logic [2:0] off;
        logic [7:0] val;
        logic       last;
    } t_tf_write;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [47:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [3:0]  i_cfg_data      = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    // Model copy of the three device masks
    logic [3:0]  lba_capable_m = '0;
    logic [3:0]  slave_m       = '0;
    logic [3:0]  channel_m     = '0;

    t_tf_write   expected_writes[$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_request  = 0;   // set by a test, picked up by the receiver
    int          hold_left     = 0;

    ata_taskfile_command_setup i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model of the block: one request -> its run of register writes
    // ------------------------------------------------------------------------
    function automatic void push_write(input logic ch, input logic [2:0] off,
                                       input logic [7:0] val, input logic last);
        t_tf_write w;
        w.chan = ch;
        w.off  = off;
        w.val  = val;
        w.last = last;
        expected_writes.push_back(w);
    endfunction

    function automatic void queue_taskfile_writes(input ata_tf_pkg::t_req r);
        logic        ch;
        logic        sl;
        logic        ext;
        logic [7:0]  sel;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  cmd;
        int unsigned addr;
        int unsigned sect;
        int unsigned head;
        int unsigned cyl;
        addr = r.lba;
        ch   = channel_m[r.device];
        sl   = slave_m[r.device];
        ext  = (r.lba >= ata_tf_pkg::LBA28_LIMIT);
        if (ext) begin
            // LBA48: head nibble of the select byte stays 0
            b0  = r.lba[7:0];
            b1  = r.lba[15:8];
            b2  = r.lba[23:16];
            sel = ata_tf_pkg::SEL_LBA | {3'b000, sl, 4'h0};
        end else if (lba_capable_m[r.device]) begin
            b0  = r.lba[7:0];
            b1  = r.lba[15:8];
            b2  = r.lba[23:16];
            sel = ata_tf_pkg::SEL_LBA | {3'b000, sl, r.lba[27:24]};
        end else begin
            // CHS, 16 heads x 63 sectors, cylinder wraps at 16 bits
            sect = addr % 63 + 1;
            head = (addr % 1008) / 63;
            cyl  = (addr / 1008) & 32'hFFFF;
            b0   = sect[7:0];
            b1   = cyl[7:0];
            b2   = cyl[15:8];
            sel  = ata_tf_pkg::SEL_CHS | {3'b000, sl, head[3:0]};
        end
        if (r.is_write)
            cmd = ext ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_WRITE;
        else
            cmd = ext ? ata_tf_pkg::CMD_READ_EXT : ata_tf_pkg::CMD_READ;

        push_write(ch, ata_tf_pkg::OFF_DEVSEL, sel, 1'b0);
        if (ext) begin
            push_write(ch, ata_tf_pkg::OFF_SECCOUNT, 8'h00, 1'b0);
            push_write(ch, ata_tf_pkg::OFF_LBA0, r.lba[31:24], 1'b0);
            push_write(ch, ata_tf_pkg::OFF_LBA1, 8'h00, 1'b0);
            push_write(ch, ata_tf_pkg::OFF_LBA2, 8'h00, 1'b0);
        end
        push_write(ch, ata_tf_pkg::OFF_SECCOUNT, r.count, 1'b0);
        push_write(ch, ata_tf_pkg::OFF_LBA0, b0, 1'b0);
        push_write(ch, ata_tf_pkg::OFF_LBA1, b1, 1'b0);
        push_write(ch, ata_tf_pkg::OFF_LBA2, b2, 1'b0);
        push_write(ch, ata_tf_pkg::OFF_COMMAND, cmd, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic ata_tf_pkg::t_req mk_req(input logic [1:0] dev, input logic wr,
                                                input logic [31:0] lba,
                                                input logic [7:0] cnt);
        ata_tf_pkg::t_req r;
        r.device   = dev;
        r.is_write = wr;
        r.lba      = lba;
        r.count    = cnt;
        return r;
    endfunction

    // Addresses weighted toward the mode boundaries and the CHS wrap point
    function automatic logic [31:0] random_lba();
        logic [31:0] a;
        case ($urandom_range(0, 4))
            0: a = $urandom;
            1: a = $urandom & 32'h0FFF_FFFF;
            2: a = $urandom_range(0, 4095);
            3: a = $urandom_range(0, 1) ? 32'h0FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h1000_0000 + $urandom_range(0, 3);
            default: a = 32'd66059280 + $urandom_range(0, 2015); // 1008*65536 - 1008
        endcase
        return a;
    endfunction

    function automatic ata_tf_pkg::t_req random_req();
        return mk_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), random_lba(),
                      8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [3:0] random_mask();
        return 4'($urandom_range(0, 15));
    endfunction

    // Entered and left at a rising edge. valid only drops for an idle gap, so
    // back-to-back requests keep it high across the handover step.
    task automatic send_request(input ata_tf_pkg::t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, r.count, r.lba, r.device};
        i_s_axis_tuser  <= r.is_write;
        do @(posedge i_clk); while (!o_s_axis_tready);
        queue_taskfile_writes(r);
    endtask

    task automatic end_burst_and_drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_writes.size() != 0);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ata_tf_pkg::CFG_LBA_CAPABLE: lba_capable_m = data;
            ata_tf_pkg::CFG_SLAVE:       slave_m       = data;
            ata_tf_pkg::CFG_CHANNEL:     channel_m     = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_masks(input logic [3:0] lba_cap, input logic [3:0] slv,
                             input logic [3:0] chn);
        write_config(ata_tf_pkg::CFG_LBA_CAPABLE, lba_cap);
        write_config(ata_tf_pkg::CFG_SLAVE, slv);
        write_config(ata_tf_pkg::CFG_CHANNEL, chn);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Masks still at reset: every device is a CHS master on the primary channel
    task automatic test_reset_defaults();
        send_idle_pct = 31;
        recv_idle_pct = 82;
        send_request(mk_req(2'd0, 1'b0, 32'd0,          8'd1));
        send_request(mk_req(2'd1, 1'b1, 32'd5000,       8'd0));
        send_request(mk_req(2'd2, 1'b0, 32'h0FFF_FFFF,  8'd255));
        send_request(mk_req(2'd3, 1'b1, 32'h8000_0000,  8'd16));
        end_burst_and_drain();
    endtask

    // dev0: LBA28 master primary, dev1: CHS slave primary,
    // dev2: LBA28 slave secondary, dev3: CHS master secondary
    task automatic test_directed_corners();
        set_masks(4'b0101, 4'b0110, 4'b1100);
        send_idle_pct = 31;
        recv_idle_pct = 82;
        send_request(mk_req(2'd0, 1'b0, 32'd0,         8'd0));
        send_request(mk_req(2'd0, 1'b1, 32'h0FFF_FFFF, 8'd255));
        send_request(mk_req(2'd2, 1'b0, 32'h0ABC_DEF1, 8'd1));
        send_request(mk_req(2'd0, 1'b1, 32'h0100_0000, 8'd2));   // LBA bit 24 in select
        send_request(mk_req(2'd2, 1'b0, 32'h0F0F_0F0F, 8'h5A));
        // first LBA48 address and the top of the range
        send_request(mk_req(2'd0, 1'b0, 32'h1000_0000, 8'd8));
        send_request(mk_req(2'd2, 1'b1, 32'hFFFF_FFFF, 8'd255));
        // LBA48 wins even on a device without LBA support
        send_request(mk_req(2'd1, 1'b0, 32'h1000_0000, 8'd0));
        send_request(mk_req(2'd3, 1'b1, 32'hF000_0000, 8'hA5));
        // CHS: sector and head rollovers
        send_request(mk_req(2'd1, 1'b0, 32'd0,         8'd1));
        send_request(mk_req(2'd1, 1'b1, 32'd62,        8'd3));
        send_request(mk_req(2'd3, 1'b0, 32'd63,        8'd4));
        send_request(mk_req(2'd3, 1'b1, 32'd1007,      8'd5));
        send_request(mk_req(2'd1, 1'b0, 32'd1008,      8'd6));
        // CHS: last block of cylinder 65534, then the wrap back to cylinder 0
        send_request(mk_req(2'd1, 1'b1, 32'd66059279,  8'd7));
        send_request(mk_req(2'd3, 1'b0, 32'd66060288,  8'd9));
        send_request(mk_req(2'd1, 1'b1, 32'h0FFF_FFFF, 8'd255));
        send_request(mk_req(2'd3, 1'b0, 32'h0FFF_FFFF, 8'd0));
        end_burst_and_drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int s_pct,
                                       input int r_pct, input logic [3:0] lba_cap,
                                       input logic [3:0] slv, input logic [3:0] chn);
        set_masks(lba_cap, slv, chn);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_items) send_request(random_req());
        end_burst_and_drain();
    endtask

    // Receiver stops for a long stretch while the sender keeps offering
    // requests; the planner fills and input tready has to drop.
    task automatic test_output_backpressure();
        set_masks(4'b1010, 4'b0011, 4'b0101);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (24) send_request(random_req());
        end_burst_and_drain();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random tready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: every accepted word against the oldest expected write
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tf_write exp_w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_writes.size() == 0) begin
                $error("unexpected word: offset %0d value %02h", o_m_axis_tdata[2:0],
                       o_m_axis_tdata[10:3]);
                error_count++;
            end else begin
                exp_w = expected_writes.pop_front();
                if (o_m_axis_tuser !== exp_w.chan) begin
                    $error("channel: expected %0d, actual %0d", exp_w.chan, o_m_axis_tuser);
                    error_count++;
                end
                if (o_m_axis_tdata[2:0] !== exp_w.off) begin
                    $error("reg_offset: expected %0d, actual %0d", exp_w.off,
                           o_m_axis_tdata[2:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[10:3] !== exp_w.val) begin
                    $error("value: expected %02h, actual %02h", exp_w.val,
                           o_m_axis_tdata[10:3]);
                    error_count++;
                end
                if (o_m_axis_tlast !== exp_w.last) begin
                    $error("last: expected %0d, actual %0d", exp_w.last, o_m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any word moving on any channel
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("** ata_taskfile_command_setup: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_corners();
        // sender mostly busy, receiver mostly stalling
        test_random_traffic(68, 31, 82, 4'h0, 4'h0, 4'h0);
        test_random_traffic(68, 31, 82, random_mask(), random_mask(), random_mask());
        // the other way round
        test_random_traffic(68, 82, 31, 4'hF, 4'hF, 4'hF);
        test_random_traffic(68, 82, 31, random_mask(), random_mask(), random_mask());
        // full rate on both sides
        test_random_traffic(68, 0, 0, random_mask(), random_mask(), random_mask());
        test_random_traffic(68, 0, 0, random_mask(), random_mask(), random_mask());
        test_output_backpressure();

        // catch any stray word after the last run
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_writes.size() != 0) begin
            $error("%0d expected writes never arrived", expected_writes.size());
            error_count++;
        end

        if (error_count == 0)
            $display("** ata_taskfile_command_setup: PASSED **");
        else
            $display("** ata_taskfile_command_setup: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/ata_tf_pkg.sv
rtl/ata_tf_plan.sv
rtl/ata_tf_seq.sv
rtl/ata_taskfile_command_setup.sv
test/tb.sv
